/* rtl/core/bcs_pkg.sv */
// Shared types and widths for the barycentric coordinate solver.
package bcs_pkg;

  localparam int W_IN   = 16;            // Q8.8 coordinate
  localparam int W_PROD = 2 * W_IN;      // product of two coordinates
  localparam int W_COF  = W_PROD + 1;    // cofactor: difference of two products
  localparam int W_TERM = W_IN + W_COF;  // coordinate times cofactor
  localparam int W_ACC  = W_TERM + 2;    // sum of three terms
  localparam int QB     = 33;            // quotient bits kept before clipping
  localparam int FRAC   = 16;            // Q16.16 weight fraction bits
  localparam int W_WGT  = 32;

  typedef struct packed {
    logic signed [W_IN-1:0] z;
    logic signed [W_IN-1:0] y;
    logic signed [W_IN-1:0] x;
  } vec_t;

  typedef struct packed {
    logic signed [W_COF-1:0] c2;
    logic signed [W_COF-1:0] c1;
    logic signed [W_COF-1:0] c0;
  } cof_t;

  typedef struct packed {
    logic signed [W_ACC-1:0] det;
    logic signed [W_ACC-1:0] na;
    logic signed [W_ACC-1:0] nb;
    logic signed [W_ACC-1:0] nc;
  } dots_t;

endpackage

/* rtl/core/barycentric_coordinate_solver.sv */
// Top level of the barycentric coordinate solver.
//  channel | dir | signals                        | contents
//  s_*     | in  | s_tvalid s_tready s_tdata[191:0] | A, B, C, P coordinates
//  m_*     | out | m_tvalid m_tready m_tdata[95:0], m_tuser[1:0] | weights, flags
//  cfg_*   | in  | cfg_we cfg_wdata[31:0]         | singular_limit
// One item per cycle while the output does not hold; stages: products, cross
// products, dot products, sums, magnitudes, 34-stage divider, output register.
// rst clears valid bits and sets singular_limit to 1.
// When the output holds, every stage holds; s_tready is low only then.
module barycentric_coordinate_solver (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // A.x A.y A.z B.x B.y B.z C.x C.y C.z P.x P.y P.z, 16 bits each
  input  logic [191:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // weight_a, weight_b, weight_c, 32 bits each
  output logic [95:0]  m_tdata,
  // singular, saturated
  output logic [1:0]   m_tuser,
  input  logic         cfg_we,
  input  logic [31:0]  cfg_wdata
);
  import bcs_pkg::*;

  localparam int DIV_LAT = QB + 1;
  localparam int PIPE    = 5 + DIV_LAT;

  logic        en;
  logic [31:0] singular_limit;
  logic        vld [PIPE];
  logic        sng [DIV_LAT+1];

  vec_t  a, b, c, p, a2, p2;
  cof_t  u, v, w;
  dots_t dots;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  assign a = s_tdata[47:0];
  assign b = s_tdata[95:48];
  assign c = s_tdata[143:96];
  assign p = s_tdata[191:144];

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      singular_limit <= 32'd1;
    end else if (cfg_we) begin
      singular_limit <= cfg_wdata;
    end
  end

  bcs_cofactor u_cof (
    .clk(clk), .en(en), .a(a), .b(b), .c(c), .p(p),
    .u(u), .v(v), .w(w), .a_out(a2), .p_out(p2)
  );

  bcs_dot u_dot (
    .clk(clk), .en(en), .a(a2), .p(p2), .u(u), .v(v), .w(w), .dots(dots)
  );

  // stage 5: magnitudes, signs, singular test
  logic [W_ACC-1:0] dmag, nmag [3];
  logic             nneg [3];
  logic [W_ACC-1:0] dabs, nabs [3];
  logic             sing_now;

  always_comb begin
    dabs    = dots.det[W_ACC-1] ? -dots.det : dots.det;
    nabs[0] = dots.na[W_ACC-1] ? -dots.na : dots.na;
    nabs[1] = dots.nb[W_ACC-1] ? -dots.nb : dots.nb;
    nabs[2] = dots.nc[W_ACC-1] ? -dots.nc : dots.nc;
    sing_now = dabs <= W_ACC'(singular_limit);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dmag    <= dabs;
      nmag[0] <= nabs[0];
      nmag[1] <= nabs[1];
      nmag[2] <= nabs[2];
      nneg[0] <= (dots.na[W_ACC-1] ^ dots.det[W_ACC-1]) && (dots.na != '0);
      nneg[1] <= (dots.nb[W_ACC-1] ^ dots.det[W_ACC-1]) && (dots.nb != '0);
      nneg[2] <= (dots.nc[W_ACC-1] ^ dots.det[W_ACC-1]) && (dots.nc != '0);
    end
  end

  // three divider lanes
  logic signed [W_WGT-1:0] wgt [3];
  logic                    lsat [3];

  for (genvar li = 0; li < 3; li++) begin : g_lane
    bcs_divider u_div (
      .clk(clk), .en(en), .nmag(nmag[li]), .dmag(dmag), .neg(nneg[li]),
      .weight(wgt[li]), .sat(lsat[li])
    );
  end

  // valid and singular flags travel alongside the data
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PIPE; i++) vld[i] <= 1'b0;
    end else if (en) begin
      vld[0] <= s_tvalid;
      for (int i = 1; i < PIPE; i++) vld[i] <= vld[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sng[0] <= sing_now;
      for (int i = 1; i <= DIV_LAT; i++) sng[i] <= sng[i-1];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= vld[PIPE-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (sng[DIV_LAT]) begin
        m_tdata <= '0;
        m_tuser <= 2'b01;
      end else begin
        m_tdata <= {wgt[2], wgt[1], wgt[0]};
        m_tuser <= {lsat[0] | lsat[1] | lsat[2], 1'b0};
      end
    end
  end

endmodule

/* rtl/core/bcs_cofactor.sv */
// Two stages: coordinate products, then the three cross products.
module bcs_cofactor (
  input  logic          clk,
  input  logic          en,
  input  bcs_pkg::vec_t a,
  input  bcs_pkg::vec_t b,
  input  bcs_pkg::vec_t c,
  input  bcs_pkg::vec_t p,
  output bcs_pkg::cof_t u,
  output bcs_pkg::cof_t v,
  output bcs_pkg::cof_t w,
  output bcs_pkg::vec_t a_out,
  output bcs_pkg::vec_t p_out
);
  import bcs_pkg::*;

  // products, two per cofactor entry: [entry][0]-[entry][1]
  logic signed [W_PROD-1:0] pr [9][2];
  vec_t a_d, p_d;

  // stage 1: products
  always_ff @(posedge clk) begin
    if (en) begin
      pr[0][0] <= b.y * c.z;  pr[0][1] <= b.z * c.y;
      pr[1][0] <= b.z * c.x;  pr[1][1] <= b.x * c.z;
      pr[2][0] <= b.x * c.y;  pr[2][1] <= b.y * c.x;
      pr[3][0] <= c.y * a.z;  pr[3][1] <= c.z * a.y;
      pr[4][0] <= c.z * a.x;  pr[4][1] <= c.x * a.z;
      pr[5][0] <= c.x * a.y;  pr[5][1] <= c.y * a.x;
      pr[6][0] <= a.y * b.z;  pr[6][1] <= a.z * b.y;
      pr[7][0] <= a.z * b.x;  pr[7][1] <= a.x * b.z;
      pr[8][0] <= a.x * b.y;  pr[8][1] <= a.y * b.x;
      a_d <= a;
      p_d <= p;
    end
  end

  // stage 2: differences
  always_ff @(posedge clk) begin
    if (en) begin
      u.c0 <= W_COF'(pr[0][0]) - W_COF'(pr[0][1]);
      u.c1 <= W_COF'(pr[1][0]) - W_COF'(pr[1][1]);
      u.c2 <= W_COF'(pr[2][0]) - W_COF'(pr[2][1]);
      v.c0 <= W_COF'(pr[3][0]) - W_COF'(pr[3][1]);
      v.c1 <= W_COF'(pr[4][0]) - W_COF'(pr[4][1]);
      v.c2 <= W_COF'(pr[5][0]) - W_COF'(pr[5][1]);
      w.c0 <= W_COF'(pr[6][0]) - W_COF'(pr[6][1]);
      w.c1 <= W_COF'(pr[7][0]) - W_COF'(pr[7][1]);
      w.c2 <= W_COF'(pr[8][0]) - W_COF'(pr[8][1]);
      a_out <= a_d;
      p_out <= p_d;
    end
  end

endmodule

/* rtl/core/bcs_dot.sv */
// Two stages: determinant and numerator dot products (multiply, then sum).
module bcs_dot (
  input  logic          clk,
  input  logic          en,
  input  bcs_pkg::vec_t a,
  input  bcs_pkg::vec_t p,
  input  bcs_pkg::cof_t u,
  input  bcs_pkg::cof_t v,
  input  bcs_pkg::cof_t w,
  output bcs_pkg::dots_t dots
);
  import bcs_pkg::*;

  // terms: [0] det, [1] na, [2] nb, [3] nc; three terms each
  logic signed [W_TERM-1:0] tm [4][3];

  // stage 3: 16 x 33 products
  always_ff @(posedge clk) begin
    if (en) begin
      tm[0][0] <= a.x * u.c0;  tm[0][1] <= a.y * u.c1;  tm[0][2] <= a.z * u.c2;
      tm[1][0] <= p.x * u.c0;  tm[1][1] <= p.y * u.c1;  tm[1][2] <= p.z * u.c2;
      tm[2][0] <= p.x * v.c0;  tm[2][1] <= p.y * v.c1;  tm[2][2] <= p.z * v.c2;
      tm[3][0] <= p.x * w.c0;  tm[3][1] <= p.y * w.c1;  tm[3][2] <= p.z * w.c2;
    end
  end

  // stage 4: three-term sums
  always_ff @(posedge clk) begin
    if (en) begin
      dots.det <= W_ACC'(tm[0][0]) + W_ACC'(tm[0][1]) + W_ACC'(tm[0][2]);
      dots.na  <= W_ACC'(tm[1][0]) + W_ACC'(tm[1][1]) + W_ACC'(tm[1][2]);
      dots.nb  <= W_ACC'(tm[2][0]) + W_ACC'(tm[2][1]) + W_ACC'(tm[2][2]);
      dots.nc  <= W_ACC'(tm[3][0]) + W_ACC'(tm[3][1]) + W_ACC'(tm[3][2]);
    end
  end

endmodule

/* rtl/core/bcs_divider.sv */
// Pipelined restoring divider: floor(nmag * 2^16 / dmag), one quotient bit
// per stage, then Q16.16 clipping and sign. Pipeline of QB + 1 registers.
module bcs_divider (
  input  logic                            clk,
  input  logic                            en,
  input  logic [bcs_pkg::W_ACC-1:0]       nmag,
  input  logic [bcs_pkg::W_ACC-1:0]       dmag,
  input  logic                            neg,
  output logic signed [bcs_pkg::W_WGT-1:0] weight,
  output logic                            sat
);
  import bcs_pkg::*;

  localparam int SHIFT = QB - FRAC;  // dividend bits below the quotient window

  logic [W_ACC-1:0] rem  [QB+1];
  logic [W_ACC-1:0] num  [QB+1];
  logic [W_ACC-1:0] den  [QB+1];
  logic [QB-1:0]    quo  [QB+1];
  logic             ovf  [QB+1];
  logic             sgn  [QB+1];
  logic [W_ACC:0]   hi;

  // prep stage: leading part of the dividend, overflow when quotient >= 2^QB
  assign hi = {1'b0, nmag} >> SHIFT;

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= W_ACC'(hi);
      ovf[0] <= hi >= {1'b0, dmag};
      num[0] <= nmag;
      den[0] <= dmag;
      sgn[0] <= neg;
      quo[0] <= '0;
    end
  end

  // one quotient bit per stage
  for (genvar gi = 0; gi < QB; gi++) begin : g_stage
    localparam int K = QB - 1 - gi;
    logic           nbit;
    logic [W_ACC:0] shifted;
    logic [W_ACC:0] diff;
    logic           ge;

    if (K >= FRAC) begin : g_bit
      assign nbit = num[gi][K-FRAC];
    end else begin : g_zero
      assign nbit = 1'b0;
    end

    assign shifted = {rem[gi], nbit};
    assign diff    = shifted - {1'b0, den[gi]};
    assign ge      = shifted >= {1'b0, den[gi]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[gi+1] <= ge ? diff[W_ACC-1:0] : shifted[W_ACC-1:0];
        quo[gi+1] <= {quo[gi][QB-2:0], ge};
        num[gi+1] <= num[gi];
        den[gi+1] <= den[gi];
        ovf[gi+1] <= ovf[gi];
        sgn[gi+1] <= sgn[gi];
      end
    end
  end

  // clip to Q16.16 range and apply sign
  logic [QB-1:0] lim;
  logic [QB-1:0] mag;
  logic          over;

  always_comb begin
    lim    = sgn[QB] ? QB'(33'h0_8000_0000) : QB'(33'h0_7FFF_FFFF);
    over   = ovf[QB] || (quo[QB] > lim);
    mag    = over ? lim : quo[QB];
    sat    = over;
    weight = sgn[QB] ? -mag[W_WGT-1:0] : mag[W_WGT-1:0];
  end

endmodule

/* rtl/core/bcs_checker.sv */
// Port-level assertions for the solver, bound to the top level.
module bcs_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [95:0]  m_tdata,
  input logic [1:0]   m_tuser
);

  // output valid stays high while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output item dropped under stall");

  // input side stalls only when the output is stalled
  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not follow output stall");

  // singular results carry zero weights and no clipping
  a_sing: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> (m_tdata == '0) && !m_tuser[1])
    else $error("singular item with nonzero weights or clip flag");

  // nothing comes out right after reset
  a_rst: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("output valid right after reset");

endmodule

bind barycentric_coordinate_solver bcs_checker u_bcs_checker (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);
